// ===== design/inactive_aging_scheduler_macros.svh =====
// assertion helpers shared by the scheduler
`ifndef INACTIVE_AGING_SCHEDULER_MACROS_SVH
`define INACTIVE_AGING_SCHEDULER_MACROS_SVH

// same-cycle implication, checked out of reset
`define IAS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define IAS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/ias_pkg.sv =====
`default_nettype none

package ias_pkg;

    localparam int SLOT_W = 3;
    localparam int PRIO_W = 8;
    localparam int MAX_SLOTS = 8;

    // request codes
    localparam logic [1:0] FUNC_SCHED   = 2'd0;
    localparam logic [1:0] FUNC_CLR_ONE = 2'd1;
    localparam logic [1:0] FUNC_CLR_ALL = 2'd2;

    typedef logic [2:0] step_t;

    // program addresses
    localparam step_t STEP_WAIT = 3'd0;
    localparam step_t STEP_AGE  = 3'd1;
    localparam step_t STEP_PICK = 3'd2;
    localparam step_t STEP_CLR1 = 3'd3;
    localparam step_t STEP_CLRA = 3'd4;
    localparam step_t STEP_OUT  = 3'd5;

    typedef enum logic [2:0] {
        SEQ_GOTO     = 3'd0,
        SEQ_DISPATCH = 3'd1,
        SEQ_LOOP     = 3'd2,
        SEQ_WAITOUT  = 3'd3
    } seq_t;

    typedef struct packed {
        logic  take;
        logic  age;
        logic  pick;
        logic  clr1;
        logic  clra;
        logic  emit;
        seq_t  seq;
        step_t target;
    } uword_t;

    function automatic uword_t ucode_rom(input step_t addr);
        uword_t w;
        w = '{take: 1'b0, age: 1'b0, pick: 1'b0, clr1: 1'b0, clra: 1'b0,
              emit: 1'b0, seq: SEQ_GOTO, target: STEP_WAIT};
        case (addr)
            STEP_WAIT: begin
                w.take = 1'b1;
                w.seq  = SEQ_DISPATCH;
            end
            STEP_AGE: begin
                w.age    = 1'b1;
                w.seq    = SEQ_LOOP;
                w.target = STEP_PICK;
            end
            STEP_PICK: begin
                w.pick   = 1'b1;
                w.target = STEP_OUT;
            end
            STEP_CLR1: begin
                w.clr1   = 1'b1;
                w.target = STEP_OUT;
            end
            STEP_CLRA: begin
                w.clra   = 1'b1;
                w.target = STEP_OUT;
            end
            STEP_OUT: begin
                w.emit   = 1'b1;
                w.seq    = SEQ_WAITOUT;
                w.target = STEP_WAIT;
            end
            default: begin
                w.target = STEP_WAIT;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== design/inactive_aging_scheduler.sv =====
`default_nettype none
// Aging slot scheduler. Each request on the s_ channel carries a function code
// in s_tuser: schedule, clear one slot's age, or clear all ages. A schedule
// request ages every ready slot from 1 upward except the running one by its
// 8-bit priority (saturating at AGE_BITS), picks the ready slot with the
// greatest age (ties to the higher priority, then the lower index), resets
// that slot's age to its priority and returns it; with no ready slot it
// returns idle slot 0 with the idle flag set. Every request yields exactly one
// result. A small microcode program steps a shared add/saturate/compare unit
// through one slot per cycle: a schedule request runs the AGE scan over slots
// 1 to NUM_SLOTS-1, then PICK, then OUT; a clear request runs CLR1 or CLRA,
// then OUT. OUT waits until the output register is free, and the next request
// is accepted the cycle after the result is loaded into it. Ages are zero after reset.

`include "inactive_aging_scheduler_macros.svh"

module inactive_aging_scheduler #(
    parameter int NUM_SLOTS = 8,
    parameter int AGE_BITS  = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // request channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // current_slot[2:0], ready_mask[10:3], priority_set[74:11],
    // target_slot[77:75], zero fill [79:78]
    input  wire logic [79:0] s_tdata,
    // func[1:0]
    input  wire logic [1:0]  s_tuser,
    // result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // next_slot[2:0], zero fill [7:3]
    output logic [7:0]       m_tdata,
    // chose_idle[0]
    output logic [0:0]       m_tuser
);

    localparam int IDX_W = $clog2(NUM_SLOTS);
    localparam int SLOT_W = ias_pkg::SLOT_W;
    localparam int PRIO_W = ias_pkg::PRIO_W;
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(NUM_SLOTS - 1);
    localparam logic [IDX_W-1:0] FIRST_IDX = IDX_W'(1);
    localparam logic [SLOT_W:0]  SLOT_LIMIT = (SLOT_W+1)'(NUM_SLOTS);
    localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

    // microcode sequencer
    ias_pkg::step_t step_reg, step_next;
    ias_pkg::uword_t uw;

    // latched request
    logic [1:0]        func_reg;
    logic [SLOT_W-1:0] cur_reg;
    logic [7:0]        ready_reg;
    logic [63:0]       prio_reg;
    logic [SLOT_W-1:0] target_reg;

    // slot scan state
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic                found_reg, found_next;
    logic [IDX_W-1:0]    best_reg, best_next;
    logic [AGE_BITS-1:0] best_age_reg, best_age_next;
    logic [PRIO_W-1:0]   best_prio_reg, best_prio_next;

    // pending result and output register
    logic [SLOT_W-1:0] res_slot_reg, res_slot_next;
    logic              res_idle_reg, res_idle_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [SLOT_W-1:0] m_slot_reg;
    logic              m_idle_reg;

    // age store, one entry per slot
    logic [AGE_BITS-1:0] age_reg [NUM_SLOTS];

    logic                accept;
    logic                out_free;
    logic [SLOT_W-1:0]   idx_slot;
    logic [PRIO_W-1:0]   prio_arr [ias_pkg::MAX_SLOTS];
    logic [PRIO_W-1:0]   cur_prio;
    logic [AGE_BITS-1:0] cur_age;
    logic [AGE_BITS:0]   age_sum;
    logic [AGE_BITS-1:0] new_age;
    logic                slot_ready;
    logic                do_aging;
    logic                better;
    logic                target_ok;

    assign uw       = ias_pkg::ucode_rom(step_reg);
    assign s_tready = uw.take;
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'd0, m_slot_reg};
    assign m_tuser  = m_idle_reg;

    // unpack priorities
    always_comb begin
        for (int i = 0; i < ias_pkg::MAX_SLOTS; i++) begin
            prio_arr[i] = prio_reg[PRIO_W*i +: PRIO_W];
        end
    end

    // shared add / saturate / compare unit for the slot under scan
    assign idx_slot   = SLOT_W'(idx_reg);
    assign cur_prio   = prio_arr[idx_slot];
    assign cur_age    = age_reg[idx_reg];
    assign slot_ready = ready_reg[idx_slot];
    assign do_aging   = uw.age && slot_ready && (idx_slot != cur_reg);
    assign age_sum    = {1'b0, cur_age} + (AGE_BITS+1)'(cur_prio);
    // only an aged slot can saturate, the others keep their age
    assign new_age    = !do_aging ? cur_age :
                        (age_sum[AGE_BITS] ? AGE_MAX : age_sum[AGE_BITS-1:0]);
    // strict compares keep the lower index on a full tie
    assign better     = !found_reg || (new_age > best_age_reg) ||
                        ((new_age == best_age_reg) && (cur_prio > best_prio_reg));
    assign target_ok  = {1'b0, target_reg} < SLOT_LIMIT;

    // step counter with conditional jumps
    always_comb begin
        step_next = step_reg;
        case (uw.seq)
            ias_pkg::SEQ_GOTO: begin
                step_next = uw.target;
            end
            ias_pkg::SEQ_DISPATCH: begin
                if (accept) begin
                    case (s_tuser)
                        ias_pkg::FUNC_SCHED:   step_next = ias_pkg::STEP_AGE;
                        ias_pkg::FUNC_CLR_ONE: step_next = ias_pkg::STEP_CLR1;
                        ias_pkg::FUNC_CLR_ALL: step_next = ias_pkg::STEP_CLRA;
                        default:               step_next = ias_pkg::STEP_OUT;
                    endcase
                end
            end
            ias_pkg::SEQ_LOOP: begin
                if (idx_reg == LAST_IDX) begin
                    step_next = uw.target;
                end
            end
            ias_pkg::SEQ_WAITOUT: begin
                if (out_free) begin
                    step_next = uw.target;
                end
            end
            default: begin
                step_next = ias_pkg::STEP_WAIT;
            end
        endcase
    end

    // scan datapath
    always_comb begin
        idx_next       = idx_reg;
        found_next     = found_reg;
        best_next      = best_reg;
        best_age_next  = best_age_reg;
        best_prio_next = best_prio_reg;
        res_slot_next  = res_slot_reg;
        res_idle_next  = res_idle_reg;
        if (accept) begin
            idx_next      = FIRST_IDX;
            found_next    = 1'b0;
            res_slot_next = '0;
            res_idle_next = 1'b0;
        end
        if (uw.age) begin
            if (idx_reg != LAST_IDX) begin
                idx_next = idx_reg + FIRST_IDX;
            end
            if (slot_ready && better) begin
                found_next     = 1'b1;
                best_next      = idx_reg;
                best_age_next  = new_age;
                best_prio_next = cur_prio;
            end
        end
        if (uw.pick) begin
            res_slot_next = found_reg ? SLOT_W'(best_reg) : '0;
            res_idle_next = !found_reg;
        end
    end

    // output register takes the result when the far side is free
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (uw.emit && out_free) begin
            m_tvalid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg     <= ias_pkg::STEP_WAIT;
            m_tvalid_reg <= 1'b0;
            found_reg    <= 1'b0;
        end else begin
            step_reg     <= step_next;
            m_tvalid_reg <= m_tvalid_next;
            found_reg    <= found_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            func_reg   <= s_tuser;
            cur_reg    <= s_tdata[2:0];
            ready_reg  <= s_tdata[10:3];
            prio_reg   <= s_tdata[74:11];
            target_reg <= s_tdata[77:75];
        end
        idx_reg       <= idx_next;
        best_reg      <= best_next;
        best_age_reg  <= best_age_next;
        best_prio_reg <= best_prio_next;
        res_slot_reg  <= res_slot_next;
        res_idle_reg  <= res_idle_next;
        if (uw.emit && out_free) begin
            m_slot_reg <= res_slot_reg;
            m_idle_reg <= res_idle_reg;
        end
    end

    // age store: one scan write, one pick write or a clear per step
    always_ff @(posedge aclk) begin
        if (!aresetn || uw.clra) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                age_reg[i] <= '0;
            end
        end else begin
            if (uw.age) begin
                age_reg[idx_reg] <= new_age;
            end
            if (uw.pick && found_reg) begin
                age_reg[best_reg] <= AGE_BITS'(best_prio_reg);
            end
            if (uw.clr1 && target_ok) begin
                age_reg[target_reg[IDX_W-1:0]] <= '0;
            end
        end
    end

    // a sequential block: no new request right after one is taken
    `IAS_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "request overlap")
    // an idle result never names a slot
    `IAS_ASSERT_NOW(a_idle_slot_zero, m_tvalid_reg && m_idle_reg, m_slot_reg == '0, "idle slot")
    // a non-schedule request leaves the result at zero
    `IAS_ASSERT_NOW(a_clear_zero, uw.emit && (func_reg != ias_pkg::FUNC_SCHED), (res_slot_reg == '0) && !res_idle_reg, "clear result")
    // the result only appears out of the emit step
    `IAS_ASSERT_NOW(a_emit_src, $rose(m_tvalid_reg), $past(step_reg) == ias_pkg::STEP_OUT, "stray result")

endmodule

`default_nettype wire
